### rtl/core/spmq_pkg.sv
// Shared types, field widths and codes for the strict priority multi-queue.
// Used by spmq_ctrl, spmq_dp and strict_priority_multi_queue_unit.
package spmq_pkg;

    // Default configuration
    localparam int QUEUE_DEPTH_DEF  = 16;
    localparam int LEVELS_DEF       = 4;
    localparam int ACTION_KINDS_DEF = 4;

    // Field widths
    localparam int CMD_W       = 1;
    localparam int LEVEL_W     = 3;
    localparam int PID_W       = 22;
    localparam int ACT_W       = 4;
    localparam int STATUS_W    = 2;
    localparam int OUT_LEVEL_W = 2;
    localparam int JOB_W       = PID_W + ACT_W;
    localparam int IN_DATA_W   = 32;
    localparam int OUT_DATA_W  = 32;

    // Commands
    localparam logic [CMD_W-1:0] CMD_PUSH = 1'b0;
    localparam logic [CMD_W-1:0] CMD_POP  = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_LEVEL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;  // latch the accepted input transfer
        logic exec;     // run the push or pop on the queues
        logic load;     // move registered read data into the result
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic out_free; // result register can take a new result this cycle
        logic pop_hit;  // latched command is a pop and some level holds a job
    } t_stat;

endpackage

### rtl/core/spmq_ctrl.sv
// Sequencer for the strict priority multi-queue: input handshake and step control.
// Depends on spmq_pkg for the command and status structs.
module spmq_ctrl
    import spmq_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_s_tvalid,
    output logic  o_s_tready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_LOAD = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_s_tready  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                // wait until the result register can take the outcome
                if (i_stat.out_free) begin
                    o_cmd.exec = 1'b1;
                    n_state    = i_stat.pop_hit ? S_LOAD : S_IDLE;
                end
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_load_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD) |-> ($past(r_state) == S_EXEC && $past(i_stat.pop_hit)))
        else $error("load step not preceded by a popping exec step");

    a_capture_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> (r_state == S_EXEC))
        else $error("captured transfer did not enter exec step");

endmodule

### rtl/core/spmq_dp.sv
// Datapath of the strict priority multi-queue: job store, per-level pointers and
// fill counts, priority pick and result register. Depends on spmq_pkg.
module spmq_dp
    import spmq_pkg::*;
#(
    parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
    parameter int LEVELS       = LEVELS_DEF,
    parameter int ACTION_KINDS = ACTION_KINDS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_stat                 o_stat,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    input  logic [CMD_W-1:0]      i_s_tuser,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    output logic [STATUS_W-1:0]   o_m_tuser
);

    localparam int PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int LVL_W     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int ADDR_W    = LVL_W + PTR_W;
    localparam int MEM_DEPTH = 1 << ADDR_W;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    // Latched input transfer
    logic [CMD_W-1:0]   r_cmd;
    logic [LEVEL_W-1:0] r_level;
    logic [PID_W-1:0]   r_pid;
    logic [ACT_W-1:0]   r_act;

    // Queue state
    logic [PTR_W-1:0] r_head [LEVELS];
    logic [PTR_W-1:0] r_tail [LEVELS];
    logic [CNT_W-1:0] r_fill [LEVELS];
    logic [JOB_W-1:0] mem    [MEM_DEPTH];
    logic [JOB_W-1:0] r_rd_data;
    logic [LVL_W-1:0] r_sel_lvl;

    // Result register
    logic                   r_out_valid;
    logic [STATUS_W-1:0]    r_out_status;
    logic [OUT_LEVEL_W-1:0] r_out_level;
    logic [PID_W-1:0]       r_out_pid;
    logic [ACT_W-1:0]       r_out_act;
    logic                   r_out_ok;

    logic [LVL_W-1:0] lvl_idx;
    logic             lvl_bad;
    logic             lvl_full;
    logic             push_ok;
    logic             pop_hit;
    logic [LVL_W-1:0] sel_idx;
    logic             any_ne;

    // Capture accepted transfer
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cmd   <= i_s_tuser;
            r_level <= i_s_tdata[LEVEL_W-1:0];
            r_pid   <= i_s_tdata[LEVEL_W +: PID_W];
            r_act   <= i_s_tdata[LEVEL_W+PID_W +: ACT_W];
        end
    end

    // Push checks
    assign lvl_idx  = LVL_W'(r_level);
    assign lvl_bad  = (int'(r_level) >= LEVELS);
    assign lvl_full = !lvl_bad && (r_fill[lvl_idx] == CNT_FULL);
    assign push_ok  = (r_cmd == CMD_PUSH) && !lvl_bad && !lvl_full;

    // Pick the lowest-numbered non-empty level
    always_comb begin
        sel_idx = '0;
        any_ne  = 1'b0;
        for (int i = LEVELS - 1; i >= 0; i--) begin
            if (r_fill[i] != '0) begin
                sel_idx = LVL_W'(i);
                any_ne  = 1'b1;
            end
        end
    end

    assign pop_hit         = (r_cmd == CMD_POP) && any_ne;
    assign o_stat.pop_hit  = pop_hit;
    assign o_stat.out_free = !r_out_valid || i_m_tready;

    // Pointer and fill count update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LEVELS; i++) begin
                r_head[i] <= '0;
                r_tail[i] <= '0;
                r_fill[i] <= '0;
            end
        end else if (i_cmd.exec) begin
            if (push_ok) begin
                r_tail[lvl_idx] <= (r_tail[lvl_idx] == PTR_LAST) ? '0
                                   : r_tail[lvl_idx] + 1'b1;
                r_fill[lvl_idx] <= r_fill[lvl_idx] + 1'b1;
            end else if (pop_hit) begin
                r_head[sel_idx] <= (r_head[sel_idx] == PTR_LAST) ? '0
                                   : r_head[sel_idx] + 1'b1;
                r_fill[sel_idx] <= r_fill[sel_idx] - 1'b1;
            end
        end
    end

    // Job store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && push_ok) begin
            mem[{lvl_idx, r_tail[lvl_idx]}] <= {r_act, r_pid};
        end
        if (i_cmd.exec && pop_hit) begin
            r_rd_data <= mem[{sel_idx, r_head[sel_idx]}];
            r_sel_lvl <= sel_idx;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && !pop_hit) begin
            r_out_level <= '0;
            r_out_pid   <= '0;
            r_out_act   <= '0;
            r_out_ok    <= 1'b0;
            if (r_cmd == CMD_POP) begin
                r_out_status <= ST_EMPTY;
            end else if (lvl_bad) begin
                r_out_status <= ST_BAD_LEVEL;
            end else if (lvl_full) begin
                r_out_status <= ST_FULL;
            end else begin
                r_out_status <= ST_OK;
            end
        end else if (i_cmd.load) begin
            r_out_status <= ST_OK;
            r_out_level  <= OUT_LEVEL_W'(r_sel_lvl);
            r_out_pid    <= r_rd_data[PID_W-1:0];
            r_out_act    <= r_rd_data[PID_W +: ACT_W];
            r_out_ok     <= (int'(r_rd_data[PID_W +: ACT_W]) < ACTION_KINDS);
        end
    end

    // Result valid: set on a new result, clear when the transfer completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((i_cmd.exec && !pop_hit) || i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_status;
    assign o_m_tdata  = OUT_DATA_W'({r_out_ok, r_out_act, r_out_pid, r_out_level});

    a_exec_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec |-> (!r_out_valid || i_m_tready))
        else $error("exec step while result register is occupied");

    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |=> r_out_valid)
        else $error("popped job not presented");

    a_pop_hit_level_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && pop_hit) |=> (r_fill[r_sel_lvl] == $past(r_fill[sel_idx]) - 1'b1))
        else $error("pop did not consume one job from the picked level");

endmodule

### rtl/core/strict_priority_multi_queue_unit.sv
// Strict priority multi-queue: LEVELS FIFOs of jobs, push by level, pop from level 0 first.
// Push: the input is captured, then exec writes the result; a popped job adds a load step (registered job store read).
// One item in flight; the next input is taken once the result is loaded, so the unit takes no
// new item before it is through with the last, and the exec step waits while the output is stalled.
// Reset (i_rst_n low, synchronous) empties every level; the job store itself is not cleared.
// Depends on spmq_pkg, spmq_ctrl and spmq_dp.
module strict_priority_multi_queue_unit
    import spmq_pkg::*;
#(
    parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
    parameter int LEVELS       = LEVELS_DEF,
    parameter int ACTION_KINDS = ACTION_KINDS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // level[2:0], process_id[24:3], action_code[28:25], zero fill
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    // command[0]
    input  logic [CMD_W-1:0]      i_s_tuser,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // out_level[1:0], out_process_id[23:2], out_action_code[27:24], action_ok[28], zero fill
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    // status[1:0]
    output logic [STATUS_W-1:0]   o_m_tuser
);

    t_cmd  cmd;
    t_stat stat;

    spmq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    spmq_dp #(
        .QUEUE_DEPTH  (QUEUE_DEPTH),
        .LEVELS       (LEVELS),
        .ACTION_KINDS (ACTION_KINDS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

endmodule

### verif/strict_priority_multi_queue_unit_tb.sv
// Self-checking testbench for strict_priority_multi_queue_unit: directed table, then random push/pop.
// Checks every result transfer against a queue-based priority model. Depends on spmq_pkg.
module strict_priority_multi_queue_unit_tb;
    import spmq_pkg::*;

    localparam int QUEUE_DEPTH  = QUEUE_DEPTH_DEF;
    localparam int LEVELS       = LEVELS_DEF;
    localparam int ACTION_KINDS = ACTION_KINDS_DEF;
    localparam int RANDOM_ITEMS = 420;
    localparam int N_DIR        = 21;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [LEVEL_W-1:0] lvl;
        logic [PID_W-1:0]   pid;
        logic [ACT_W-1:0]   act;
    } t_job_cmd;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [OUT_LEVEL_W-1:0] lvl;
        logic [PID_W-1:0]       pid;
        logic [ACT_W-1:0]       act;
        logic                   act_ok;
    } t_pop_result;

    typedef struct packed {
        logic [PID_W-1:0] pid;
        logic [ACT_W-1:0] act;
    } t_job;

    // Directed row: typed rows carry a status with all other result fields zero
    typedef struct {
        logic [CMD_W-1:0]    cmd;
        logic [LEVEL_W-1:0]  lvl;
        logic [PID_W-1:0]    pid;
        logic [ACT_W-1:0]    act;
        bit                  typed;
        logic [STATUS_W-1:0] status;
    } t_dir_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata;
    logic [CMD_W-1:0]      i_s_tuser;
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    logic [OUT_DATA_W-1:0] o_m_tdata;
    logic [STATUS_W-1:0]   o_m_tuser;

    // Model state and scoreboard
    t_job        level_jobs [LEVELS][$];
    t_pop_result pending_results [$];
    bit          calm;
    int          mismatch_cnt;
    int          checked_cnt;
    int          status_cnt [4];
    int          sent_cnt;

    t_dir_row dir_rows [N_DIR] = '{
        '{CMD_POP,  3'd0, 22'h000000, 4'd0,  1'b1, ST_EMPTY},
        '{CMD_PUSH, 3'd4, 22'h00007b, 4'd1,  1'b1, ST_BAD_LEVEL},
        '{CMD_PUSH, 3'd5, 22'h2aaaaa, 4'd5,  1'b1, ST_BAD_LEVEL},
        '{CMD_PUSH, 3'd6, 22'h155555, 4'd10, 1'b1, ST_BAD_LEVEL},
        '{CMD_PUSH, 3'd7, 22'h3fffff, 4'd15, 1'b1, ST_BAD_LEVEL},
        '{CMD_PUSH, 3'd0, 22'h3fffff, 4'd15, 1'b1, ST_OK},
        '{CMD_PUSH, 3'd3, 22'h000000, 4'd0,  1'b1, ST_OK},
        '{CMD_PUSH, 3'd1, 22'h2aaaaa, 4'd3,  1'b1, ST_OK},
        '{CMD_PUSH, 3'd2, 22'h155555, 4'd4,  1'b1, ST_OK},
        '{CMD_POP,  3'd0, 22'h000000, 4'd0,  1'b0, ST_OK},
        '{CMD_POP,  3'd0, 22'h000000, 4'd0,  1'b0, ST_OK},
        '{CMD_POP,  3'd0, 22'h000000, 4'd0,  1'b0, ST_OK},
        '{CMD_POP,  3'd0, 22'h000000, 4'd0,  1'b0, ST_OK},
        '{CMD_POP,  3'd0, 22'h000000, 4'd0,  1'b1, ST_EMPTY},
        '{CMD_PUSH, 3'd3, 22'h000001, 4'd1,  1'b1, ST_OK},
        '{CMD_PUSH, 3'd0, 22'h000002, 4'd2,  1'b1, ST_OK},
        '{CMD_POP,  3'd0, 22'h000000, 4'd0,  1'b0, ST_OK},
        '{CMD_PUSH, 3'd0, 22'h000003, 4'd0,  1'b1, ST_OK},
        '{CMD_POP,  3'd0, 22'h000000, 4'd0,  1'b0, ST_OK},
        '{CMD_POP,  3'd0, 22'h000000, 4'd0,  1'b0, ST_OK},
        '{CMD_POP,  3'd7, 22'h3fffff, 4'd15, 1'b1, ST_EMPTY}
    };

    strict_priority_multi_queue_unit #(
        .QUEUE_DEPTH  (QUEUE_DEPTH),
        .LEVELS       (LEVELS),
        .ACTION_KINDS (ACTION_KINDS)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    // Free-running clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs
    initial begin
        #4000000;
        $display("*** FAILED ***");
        $finish;
    end

    // Idle length: mostly short, sometimes long
    function automatic int gap_cycles();
        if ($urandom_range(0, 99) < 85) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // Compute the result of one command and advance the per-level job queues
    function automatic t_pop_result predict_sched(t_job_cmd c);
        t_pop_result r = '0;
        t_job        j;
        bit          found = 1'b0;
        if (c.cmd == CMD_PUSH) begin
            if (c.lvl >= LEVELS) begin
                r.status = ST_BAD_LEVEL;
            end else if (level_jobs[c.lvl].size() >= QUEUE_DEPTH) begin
                r.status = ST_FULL;
            end else begin
                j.pid = c.pid;
                j.act = c.act;
                level_jobs[c.lvl].push_back(j);
                r.status = ST_OK;
            end
        end else begin
            r.status = ST_EMPTY;
            for (int i = 0; i < LEVELS; i++) begin
                if (!found && level_jobs[i].size() != 0) begin
                    j        = level_jobs[i].pop_front();
                    found    = 1'b1;
                    r.status = ST_OK;
                    r.lvl    = i[OUT_LEVEL_W-1:0];
                    r.pid    = j.pid;
                    r.act    = j.act;
                    r.act_ok = (j.act < ACTION_KINDS);
                end
            end
        end
        return r;
    endfunction

    function automatic int jobs_held();
        int n = 0;
        for (int i = 0; i < LEVELS; i++) begin
            n += level_jobs[i].size();
        end
        return n;
    endfunction

    function automatic t_job_cmd rand_cmd(logic [CMD_W-1:0] cmd, logic [LEVEL_W-1:0] lvl);
        t_job_cmd c;
        c.cmd = cmd;
        c.lvl = lvl;
        c.pid = PID_W'($urandom());
        c.act = ACT_W'($urandom_range(0, 15));
        return c;
    endfunction

    // Drive one command, wait for its transfer, then queue the expected result
    task automatic send_cmd(input t_job_cmd c, input bit typed, input t_pop_result typed_res);
        int          gap;
        t_pop_result r;
        gap = (!calm && $urandom_range(0, 99) < 40) ? gap_cycles() : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {3'b000, c.act, c.pid, c.lvl};
        i_s_tuser  <= c.cmd;
        do @(posedge i_clk); while (!o_s_tready);
        r = predict_sched(c);
        pending_results.push_back(typed ? typed_res : r);
        sent_cnt++;
    endtask

    // Result side: random backpressure; no new stall starts while calm
    initial begin
        int stall_left;
        stall_left = 0;
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                i_m_tready <= 1'b0;
            end else if (!calm && $urandom_range(0, 99) < 25) begin
                stall_left = gap_cycles() - 1;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // Check each result transfer against the oldest expectation
    always @(posedge i_clk) begin
        t_pop_result exp_r;
        t_pop_result act_r;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            act_r.status = o_m_tuser;
            act_r.lvl    = o_m_tdata[1:0];
            act_r.pid    = o_m_tdata[23:2];
            act_r.act    = o_m_tdata[27:24];
            act_r.act_ok = o_m_tdata[28];
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result status %0d data %h", $time, o_m_tuser,
                         o_m_tdata);
                mismatch_cnt++;
            end else begin
                exp_r = pending_results.pop_front();
                checked_cnt++;
                status_cnt[exp_r.status]++;
                if (act_r.status !== exp_r.status) begin
                    $display("%0t: status expected %0d actual %0d", $time, exp_r.status,
                             act_r.status);
                    mismatch_cnt++;
                end
                if (act_r.lvl !== exp_r.lvl) begin
                    $display("%0t: level expected %0d actual %0d", $time, exp_r.lvl,
                             act_r.lvl);
                    mismatch_cnt++;
                end
                if (act_r.pid !== exp_r.pid) begin
                    $display("%0t: process id expected %h actual %h", $time, exp_r.pid,
                             act_r.pid);
                    mismatch_cnt++;
                end
                if (act_r.act !== exp_r.act) begin
                    $display("%0t: action expected %0d actual %0d", $time, exp_r.act,
                             act_r.act);
                    mismatch_cnt++;
                end
                if (act_r.act_ok !== exp_r.act_ok) begin
                    $display("%0t: action ok expected %0d actual %0d", $time, exp_r.act_ok,
                             act_r.act_ok);
                    mismatch_cnt++;
                end
            end
        end
    end

    // Stimulus and verdict
    initial begin
        t_job_cmd    c;
        t_pop_result typed_res;
        int          phase;
        int          n;
        int          tgt;
        int          r;
        mismatch_cnt = 0;
        checked_cnt  = 0;
        sent_cnt     = 0;
        status_cnt   = '{0, 0, 0, 0};
        calm         = 1'b0;
        i_rst_n      = 1'b0;
        i_s_tvalid   = 1'b0;
        i_s_tdata    = '0;
        i_s_tuser    = CMD_PUSH;

        // Hold reset, then release it
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed table
        for (int k = 0; k < N_DIR; k++) begin
            c.cmd            = dir_rows[k].cmd;
            c.lvl            = dir_rows[k].lvl;
            c.pid            = dir_rows[k].pid;
            c.act            = dir_rows[k].act;
            typed_res        = '0;
            typed_res.status = dir_rows[k].status;
            send_cmd(c, dir_rows[k].typed, typed_res);
        end

        // Random phases: fill one level, drain everything, or mix
        typed_res = '0;
        while (sent_cnt < N_DIR + RANDOM_ITEMS) begin
            phase = $urandom_range(0, 2);
            calm  = ($urandom_range(0, 4) == 0);
            if (phase == 0) begin
                tgt = $urandom_range(0, LEVELS - 1);
                n   = $urandom_range(12, 24);
                repeat (n) begin
                    r = $urandom_range(0, 99);
                    if (r < 85) begin
                        c = rand_cmd(CMD_PUSH, tgt[LEVEL_W-1:0]);
                    end else if (r < 95) begin
                        c = rand_cmd(CMD_PUSH, LEVEL_W'($urandom_range(0, LEVELS - 1)));
                    end else begin
                        c = rand_cmd(CMD_PUSH, LEVEL_W'($urandom_range(LEVELS, 7)));
                    end
                    send_cmd(c, 1'b0, typed_res);
                end
            end else if (phase == 1) begin
                n = jobs_held() + $urandom_range(0, 3);
                repeat (n) begin
                    if ($urandom_range(0, 99) < 90) begin
                        c = rand_cmd(CMD_POP, LEVEL_W'($urandom_range(0, 7)));
                    end else begin
                        c = rand_cmd(CMD_PUSH, LEVEL_W'($urandom_range(0, LEVELS - 1)));
                    end
                    send_cmd(c, 1'b0, typed_res);
                end
            end else begin
                n = $urandom_range(10, 30);
                repeat (n) begin
                    r = $urandom_range(0, 99);
                    if (r < 50) begin
                        c = rand_cmd(CMD_POP, LEVEL_W'($urandom_range(0, 7)));
                    end else if (r < 92) begin
                        c = rand_cmd(CMD_PUSH, LEVEL_W'($urandom_range(0, LEVELS - 1)));
                    end else begin
                        c = rand_cmd(CMD_PUSH, LEVEL_W'($urandom_range(LEVELS, 7)));
                    end
                    send_cmd(c, 1'b0, typed_res);
                end
            end
        end

        // Stop sending, drain outstanding results, then wait before the verdict
        calm = 1'b0;
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Sent %0d commands (%0d directed), checked %0d results", sent_cnt, N_DIR,
                 checked_cnt);
        $display("Status mix: %0d ok, %0d bad level, %0d full, %0d empty, %0d mismatches",
                 status_cnt[ST_OK], status_cnt[ST_BAD_LEVEL], status_cnt[ST_FULL],
                 status_cnt[ST_EMPTY], mismatch_cnt);
        if (mismatch_cnt == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

### strict_priority_multi_queue_unit.f
rtl/core/spmq_pkg.sv
rtl/core/spmq_ctrl.sv
rtl/core/spmq_dp.sv
rtl/core/strict_priority_multi_queue_unit.sv
verif/strict_priority_multi_queue_unit_tb.sv
